/* rtl/rfmd_pkg.sv */
// shared types and constants for the rssi follow move decision block
package rfmd_pkg;

	// opcode of an input word
	localparam logic OP_FRAME = 1'b0;
	localparam logic OP_TICK  = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_TARGET_RSSI    = 2'd0;
	localparam logic [1:0] CFG_MOVE_THRESHOLD = 2'd1;
	localparam logic [1:0] CFG_STATIONARY     = 2'd2;

	// configuration reset values
	localparam logic signed [7:0] TARGET_RSSI_RST    = -8'sd30;
	localparam logic [6:0]        MOVE_THRESHOLD_RST = 7'd1;

	// outcome codes
	localparam logic [2:0] OUT_TOO_FEW = 3'd0;
	localparam logic [2:0] OUT_SEEDED  = 3'd1;
	localparam logic [2:0] OUT_TARGET  = 3'd2;
	localparam logic [2:0] OUT_KEPT    = 3'd3;
	localparam logic [2:0] OUT_TURNED  = 3'd4;

	// speed and heading values
	localparam logic [6:0] SPEED_STOP   = 7'd0;
	localparam logic [6:0] SPEED_FULL   = 7'd100;
	localparam logic [8:0] HEADING_RST  = 9'd90;
	localparam logic [8:0] HEADING_STEP = 9'd90;
	localparam logic [8:0] HEADING_LAST = 9'd270;

	typedef struct packed {
		logic              opcode;
		logic              header_match;
		logic [63:0]       sender_id;
		logic signed [7:0] rssi;
	} in_word_t;

	typedef struct packed {
		logic [6:0] speed;
		logic [8:0] heading;
		logic [2:0] outcome;
	} out_word_t;

	// controller to datapath commands
	typedef struct packed {
		logic frame_acc;
		logic tick_acc;
		logic scan_start;
		logic scan_rd;
		logic div_load;
		logic div_step;
		logic finish;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic dec_due;
		logic scan_last;
		logic empty;
		logic div_last;
		logic out_free;
	} status_t;

endpackage

/* rtl/rfmd_ctrl.sv */
// controller state machine for the rssi follow move decision block
module rfmd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_opcode,
	output logic             in_ready,
	input  rfmd_pkg::status_t status,
	output rfmd_pkg::cmd_t    cmd
);
	import rfmd_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_SCAN   = 5'b00010,
		ST_DRAIN  = 5'b00100,
		ST_LOAD   = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q, state_d;
	logic   div_busy_q, div_busy_d;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// command decode and next state
	always_comb begin
		cmd            = '0;
		state_d        = state_q;
		div_busy_d     = div_busy_q;
		cmd.frame_acc  = accept && (in_opcode == OP_FRAME);
		cmd.tick_acc   = accept && (in_opcode == OP_TICK);
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.tick_acc && status.dec_due) begin
					cmd.scan_start = 1'b1;
					state_d        = ST_SCAN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (status.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				// divide only when every slot holds a sample
				if (div_busy_q) begin
					cmd.div_step = 1'b1;
					if (status.div_last) begin
						div_busy_d = 1'b0;
						state_d    = ST_FINISH;
					end
				end else if (status.empty) begin
					state_d = ST_FINISH;
				end else begin
					cmd.div_load = 1'b1;
					div_busy_d   = 1'b1;
				end
			end
			ST_FINISH: begin
				if (status.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			div_busy_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			div_busy_q <= div_busy_d;
		end
	end

endmodule

/* rtl/rfmd_dp.sv */
// datapath: sample history, tick counter, averaging divider and decision
module rfmd_dp #(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rfmd_pkg::in_word_t  in_data,
	input  logic               cfg_valid,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data,
	input  rfmd_pkg::cmd_t      cmd,
	output rfmd_pkg::status_t   status,
	output logic               out_valid,
	input  logic               out_ready,
	output rfmd_pkg::out_word_t out_data
);
	import rfmd_pkg::*;

	localparam int IX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int MAG_W  = 8 + IX_W;
	localparam int SUM_W  = MAG_W + 1;
	localparam int RCP_S  = MAG_W + IX_W;
	localparam int RCP_W  = MAG_W + 1;
	localparam int PROD_W = MAG_W + RCP_W;

	localparam logic [IX_W-1:0] IX_LAST = IX_W'(HISTORY_DEPTH - 1);
	// reciprocal of the depth rounded up, exact for every magnitude below 2**MAG_W
	localparam logic [RCP_W-1:0] DEPTH_RCP =
		RCP_W'(((1 << RCP_S) + HISTORY_DEPTH - 1) / HISTORY_DEPTH);

	// configuration
	logic signed [7:0] target_rssi_q;
	logic [6:0]        move_threshold_q;
	logic              stationary_q;

	// history and neighbour
	logic [7:0]            ring_mem [HISTORY_DEPTH];
	logic [HISTORY_DEPTH-1:0] ring_vld_q;
	logic [IX_W-1:0]       write_slot_q;
	logic                  nb_known_q;
	logic [63:0]           nb_id_q;

	// tick counter and its phase within one history period
	logic [7:0]      tick_count_q;
	logic [IX_W-1:0] phase_q;
	logic [7:0]      tick_next;
	logic [IX_W-1:0] phase_next;

	// scan
	logic [IX_W-1:0]   scan_ix_q;
	logic              rd_pend_s1;
	logic [7:0]        rd_data_s1;
	logic              rd_vld_s1;
	logic signed [SUM_W-1:0] sum_q;
	logic              empty_q;

	// divider
	logic [MAG_W-1:0]  mag_q;
	logic [7:0]        quo_q;
	logic              sum_neg_q;
	logic [SUM_W-1:0]  sum_abs;
	logic [PROD_W-1:0] prod;

	// decision state
	logic signed [7:0] last_avg_q;
	logic [6:0]        cur_speed_q;
	logic [8:0]        cur_heading_q;
	logic              out_valid_q;
	out_word_t         out_data_q;

	logic store;
	logic signed [7:0] avg;
	logic signed [8:0] rise;
	logic [6:0]        speed_d;
	logic [8:0]        heading_d;
	logic [2:0]        outcome_d;
	logic              upd_avg;

	// configuration writes, beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_rssi_q    <= TARGET_RSSI_RST;
			move_threshold_q <= MOVE_THRESHOLD_RST;
			stationary_q     <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_TARGET_RSSI:    target_rssi_q    <= $signed(cfg_data);
				CFG_MOVE_THRESHOLD: move_threshold_q <= cfg_data[6:0];
				CFG_STATIONARY:     stationary_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// frame word: latch first sender, store samples from it
	assign store = cmd.frame_acc && in_data.header_match &&
		(!nb_known_q || (nb_id_q == in_data.sender_id));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_known_q   <= 1'b0;
			nb_id_q      <= '0;
			write_slot_q <= '0;
			ring_vld_q   <= '0;
		end else if (store) begin
			nb_known_q               <= 1'b1;
			nb_id_q                  <= in_data.sender_id;
			ring_vld_q[write_slot_q] <= 1'b1;
			write_slot_q <= (write_slot_q == IX_LAST) ? '0 : write_slot_q + 1'b1;
		end
	end

	// history memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (store) begin
			ring_mem[write_slot_q] <= in_data.rssi;
		end
		rd_data_s1 <= ring_mem[scan_ix_q];
	end

	// tick counter; phase restarts when the counter wraps
	assign tick_next  = tick_count_q + 8'd1;
	assign phase_next = (tick_next == 8'd0 || phase_q == IX_LAST) ? '0 : phase_q + 1'b1;
	assign status.dec_due = !stationary_q && (phase_next == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_count_q <= '0;
			phase_q      <= '0;
		end else if (cmd.tick_acc) begin
			tick_count_q <= tick_next;
			phase_q      <= phase_next;
		end
	end

	// scan over the history, summing and looking for empty slots
	assign status.scan_last = (scan_ix_q == IX_LAST);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_ix_q  <= '0;
			rd_pend_s1 <= 1'b0;
			rd_vld_s1  <= 1'b0;
			sum_q      <= '0;
			empty_q    <= 1'b0;
		end else begin
			rd_pend_s1 <= cmd.scan_rd;
			rd_vld_s1  <= ring_vld_q[scan_ix_q];
			if (cmd.scan_start) begin
				scan_ix_q <= '0;
				sum_q     <= '0;
				empty_q   <= 1'b0;
			end else begin
				if (cmd.scan_rd) begin
					scan_ix_q <= status.scan_last ? '0 : scan_ix_q + 1'b1;
				end
				if (rd_pend_s1) begin
					sum_q   <= sum_q + SUM_W'($signed(rd_data_s1));
					empty_q <= empty_q || !rd_vld_s1 || (rd_data_s1 == 8'd0);
				end
			end
		end
	end

	assign status.empty = empty_q;

	// divide by the history depth: magnitude times its rounded-up reciprocal
	assign sum_abs = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
	assign prod    = PROD_W'(mag_q) * PROD_W'(DEPTH_RCP);
	assign status.div_last = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_q     <= '0;
			quo_q     <= '0;
			sum_neg_q <= 1'b0;
		end else if (cmd.div_load) begin
			mag_q     <= sum_abs[MAG_W-1:0];
			sum_neg_q <= sum_q[SUM_W-1];
		end else if (cmd.div_step) begin
			quo_q <= prod[RCP_S +: 8];
		end
	end

	// average truncated toward zero
	assign avg  = sum_neg_q ? $signed(8'(~quo_q + 8'd1)) : $signed(quo_q);
	assign rise = 9'(avg) - 9'(last_avg_q);

	// decision
	always_comb begin
		speed_d   = cur_speed_q;
		heading_d = cur_heading_q;
		outcome_d = OUT_TOO_FEW;
		upd_avg   = 1'b0;
		priority if (empty_q) begin
			speed_d = SPEED_STOP;
		end else if (last_avg_q == 8'sd0) begin
			speed_d   = SPEED_STOP;
			outcome_d = OUT_SEEDED;
			upd_avg   = 1'b1;
		end else if (avg >= target_rssi_q) begin
			speed_d   = SPEED_STOP;
			heading_d = '0;
			outcome_d = OUT_TARGET;
			upd_avg   = 1'b1;
		end else if (rise > $signed({2'b00, move_threshold_q})) begin
			speed_d   = SPEED_FULL;
			outcome_d = OUT_KEPT;
			upd_avg   = 1'b1;
		end else begin
			speed_d   = SPEED_FULL;
			heading_d = (cur_heading_q == HEADING_LAST) ? '0 : cur_heading_q + HEADING_STEP;
			outcome_d = OUT_TURNED;
			upd_avg   = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_avg_q    <= '0;
			cur_speed_q   <= SPEED_FULL;
			cur_heading_q <= HEADING_RST;
		end else if (cmd.finish) begin
			cur_speed_q   <= speed_d;
			cur_heading_q <= heading_d;
			if (upd_avg) begin
				last_avg_q <= avg;
			end
		end
	end

	// output register
	assign status.out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_data_q.speed   <= speed_d;
			out_data_q.heading <= heading_d;
			out_data_q.outcome <= outcome_d;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

/* rtl/rssi_follow_move_decision_top.sv */
// top level of the rssi follow move decision block
//
// input channel (in_valid/in_ready/in_data) takes frame words and tick words.
// a frame word from the latched neighbour writes its rssi into the history;
// frame words and ticks that do not decide are accepted back to back while idle.
// every HISTORY_DEPTH-th tick (counter wraps at 256) on a non-stationary node
// starts a decision: the history is read one slot a cycle, then the sum
// magnitude is divided by the depth with a single reciprocal multiply,
// which is skipped when the history still holds an empty slot.
// one word is worked on at a time; in_ready is low during a decision.
// the result sits in an output register: the next input word is accepted
// while it waits, but a new decision holds in its final step until the
// previous word is taken by out_ready.
// configuration writes (cfg_valid/cfg_ready) are always accepted and are
// meant for idle periods; unknown indexes are ignored.
// reset clears the history (all slots empty), neighbour, counters and
// average, sets speed 100, heading 90 and the configuration defaults.
module rssi_follow_move_decision_top #(
	parameter int HISTORY_DEPTH = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  rfmd_pkg::in_word_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output rfmd_pkg::out_word_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [7:0]          cfg_data
);
	import rfmd_pkg::*;

	cmd_t    cmd;
	status_t status;

	assign cfg_ready = 1'b1;

	// sequencing
	rfmd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_opcode (in_data.opcode),
		.in_ready  (in_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// storage and arithmetic
	rfmd_dp #(
		.HISTORY_DEPTH (HISTORY_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

/* tb/tb.sv */
// self-checking testbench for the rssi follow move decision block
`timescale 1ns / 1ps

module tb;
	import rfmd_pkg::*;

	localparam int         HIST       = 16;
	localparam int         HALF_CLK   = 6;
	localparam int         SETTLE     = 48;
	localparam int         LONG_HOLD  = 400;
	localparam int         N_SETTINGS = 6;
	localparam logic [1:0] CFG_UNUSED = 2'd3;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	in_word_t   in_data   = '0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	out_word_t  out_data;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;

	// shadow of the block: history, neighbour, counters and heading
	logic signed [7:0] hist [HIST] = '{default: '0};
	logic [3:0]        hist_slot   = '0;
	logic              peer_known  = 1'b0;
	logic [63:0]       peer_id     = '0;
	logic signed [7:0] avg_mem     = '0;
	logic [7:0]        tick_cnt    = '0;
	logic [6:0]        speed_now   = SPEED_FULL;
	logic [8:0]        heading_now = HEADING_RST;

	// shadow of the configuration registers
	logic signed [7:0] target_lvl = TARGET_RSSI_RST;
	logic [6:0]        rise_min   = MOVE_THRESHOLD_RST;
	logic              parked     = 1'b0;

	// word queues and bookkeeping
	in_word_t    words_to_send [$];
	out_word_t   moves_due [$];
	logic [63:0] peer_pick;
	int          n_queued      = 0;
	int          n_taken       = 0;
	int          n_useful      = 0;
	int          ticks_queued  = 0;
	int          wraps         = 0;
	int          n_checked     = 0;
	int          errors        = 0;
	int          outcome_tally [5] = '{default: 0};
	logic        calm          = 1'b0;
	logic        hold_req      = 1'b0;
	logic        hold_done     = 1'b0;
	int          hold_left     = 0;
	int          stall_left    = 0;
	int          send_gap      = 0;

	rssi_follow_move_decision_top #(
		.HISTORY_DEPTH(HIST)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #HALF_CLK clk = ~clk;

	// one move decision over the shadow history
	function automatic out_word_t decide_move();
		int        sum;
		int        avg;
		logic      hole;
		out_word_t r;
		sum  = 0;
		hole = 1'b0;
		for (int i = 0; i < HIST; i++) begin
			if (hist[i] == 0)
				hole = 1'b1;
			sum += hist[i];
		end
		avg = sum / HIST;
		if (hole) begin
			speed_now = SPEED_STOP;
			r.outcome = OUT_TOO_FEW;
		end else if (avg_mem == 0) begin
			// first average only seeds the stored one
			avg_mem   = avg[7:0];
			speed_now = SPEED_STOP;
			r.outcome = OUT_SEEDED;
		end else begin
			if (avg >= int'(target_lvl)) begin
				speed_now   = SPEED_STOP;
				heading_now = '0;
				r.outcome   = OUT_TARGET;
			end else if (avg - int'(avg_mem) > int'(rise_min)) begin
				speed_now = SPEED_FULL;
				r.outcome = OUT_KEPT;
			end else begin
				speed_now   = SPEED_FULL;
				heading_now = (heading_now == HEADING_LAST) ? 9'd0 : heading_now + HEADING_STEP;
				r.outcome   = OUT_TURNED;
			end
			avg_mem = avg[7:0];
		end
		r.speed   = speed_now;
		r.heading = heading_now;
		return r;
	endfunction

	// advance the shadow by one accepted word
	task automatic track_word(input in_word_t w);
		logic store;
		store = 1'b0;
		if (w.opcode == OP_FRAME) begin
			if (w.header_match) begin
				if (!peer_known) begin
					peer_known = 1'b1;
					peer_id    = w.sender_id;
					store      = 1'b1;
				end else if (peer_id == w.sender_id) begin
					store = 1'b1;
				end
			end
			if (store) begin
				hist[hist_slot] = w.rssi;
				hist_slot       = hist_slot + 1'b1;
			end
		end else begin
			tick_cnt = tick_cnt + 1'b1;
			if (tick_cnt == 0)
				wraps++;
			if (!parked && (tick_cnt % HIST) == 0)
				moves_due.push_back(decide_move());
		end
	endtask

	// input driver: pops queued words, random idle bursts
	always @(posedge clk or negedge arst_n) begin
		in_word_t nxt;
		logic     go;
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && in_ready) begin
				track_word(in_data);
				n_taken++;
			end
			if (!in_valid || in_ready) begin
				go  = 1'b0;
				nxt = in_data;
				if (send_gap > 0) begin
					send_gap--;
				end else if (words_to_send.size() > 0) begin
					if (!calm && $urandom_range(0, 9) == 0) begin
						send_gap = $urandom_range(0, 5);
					end else begin
						go  = 1'b1;
						nxt = words_to_send.pop_front();
					end
				end
				in_valid <= go;
				in_data  <= nxt;
			end
		end
	end

	// output monitor: checks each decision word, random stalls and one long hold-off
	always @(posedge clk or negedge arst_n) begin
		out_word_t want;
		logic      rdy;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (moves_due.size() == 0) begin
					$display("%0t: decision word with none expected: speed %0d heading %0d outcome %0d",
						$time, out_data.speed, out_data.heading, out_data.outcome);
					errors++;
				end else begin
					want = moves_due.pop_front();
					n_checked++;
					outcome_tally[want.outcome]++;
					if (out_data.speed !== want.speed) begin
						$display("%0t: speed mismatch: expected %0d, actual %0d",
							$time, want.speed, out_data.speed);
						errors++;
					end
					if (out_data.heading !== want.heading) begin
						$display("%0t: heading mismatch: expected %0d, actual %0d",
							$time, want.heading, out_data.heading);
						errors++;
					end
					if (out_data.outcome !== want.outcome) begin
						$display("%0t: outcome mismatch: expected %0d, actual %0d",
							$time, want.outcome, out_data.outcome);
						errors++;
					end
				end
			end
			rdy = 1'b1;
			if (hold_left > 0) begin
				hold_left--;
				rdy = 1'b0;
			end else if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				hold_left = LONG_HOLD - 1;
				rdy       = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				rdy = 1'b0;
			end else if (!calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 5);
				rdy        = 1'b0;
			end
			out_ready <= rdy;
		end
	end

	// queue one input word
	task automatic push_word(input logic op, input logic hm, input logic [63:0] id,
			input logic [7:0] v);
		in_word_t w;
		w.opcode       = op;
		w.header_match = hm;
		w.sender_id    = id;
		w.rssi         = v;
		words_to_send.push_back(w);
		n_queued++;
		if (op == OP_TICK) begin
			ticks_queued++;
			n_useful++;
		end else if (hm && id == peer_pick) begin
			n_useful++;
		end
	endtask

	task automatic push_tick();
		push_word(OP_TICK, 1'($urandom_range(0, 1)), {$urandom, $urandom},
			8'($urandom_range(0, 255)));
	endtask

	task automatic push_peer(input logic [7:0] v);
		push_word(OP_FRAME, 1'b1, peer_pick, v);
	endtask

	// frames that store nothing: bad header or foreign sender
	task automatic push_noise();
		logic [63:0] id;
		id = {$urandom, $urandom};
		case ($urandom_range(0, 3))
			0: push_word(OP_FRAME, 1'b0, peer_pick, 8'($urandom_range(0, 255)));
			1: push_word(OP_FRAME, 1'b0, id, 8'($urandom_range(0, 255)));
			default: begin
				if (id == peer_pick)
					id[0] = ~id[0];
				push_word(OP_FRAME, 1'b1, id, 8'($urandom_range(0, 255)));
			end
		endcase
	endtask

	// neighbour sample close to a level, never zero
	function automatic logic [7:0] near(input int lvl);
		int v;
		v = lvl + int'($urandom_range(0, 6)) - 3;
		return v[7:0];
	endfunction

	// some neighbour samples, then ticks up to the next decision
	task automatic run_episode();
		int mode;
		int lvl;
		int k;
		int n_ticks;
		int v;
		mode = $urandom_range(0, 11);
		lvl  = int'($urandom_range(0, 105)) - 110;
		case (mode)
			0: begin
				// alternating +1/-1 gives a zero average
				for (int i = 0; i < HIST; i++)
					push_peer((i % 2) != 0 ? 8'h01 : 8'hff);
			end
			1: begin
				for (int i = 0; i < HIST; i++)
					push_peer(8'($urandom_range(0, 255)));
			end
			2: push_peer(8'h00);
			3: begin
				v = $urandom_range(0, 1) ? 127 : -128;
				for (int i = 0; i < HIST; i++)
					push_peer(v[7:0]);
			end
			4, 5: begin
				for (int i = 0; i < HIST; i++) begin
					if ($urandom_range(0, 5) == 0)
						push_noise();
					push_peer(near(lvl));
				end
			end
			default: begin
				k = $urandom_range(0, 6);
				for (int i = 0; i < k; i++) begin
					if ($urandom_range(0, 5) == 0)
						push_noise();
					push_peer(near(lvl));
				end
			end
		endcase
		n_ticks = HIST - (ticks_queued % HIST);
		if ($urandom_range(0, 4) == 0)
			n_ticks += HIST;
		for (int i = 0; i < n_ticks; i++) begin
			if ($urandom_range(0, 7) == 0)
				push_noise();
			else if ($urandom_range(0, 9) == 0)
				push_peer(near(lvl));
			push_tick();
		end
	endtask

	// register write, left high for a following write
	task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
		cfg_index <= idx;
		cfg_data  <= val;
		cfg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			CFG_TARGET_RSSI:    target_lvl = val;
			CFG_MOVE_THRESHOLD: rise_min   = val[6:0];
			CFG_STATIONARY:     parked     = val[0];
			default: ;
		endcase
	endtask

	task automatic set_config(input int tgt, input int thr, input logic stat);
		write_reg(CFG_TARGET_RSSI, tgt[7:0]);
		write_reg(CFG_MOVE_THRESHOLD, {1'($urandom_range(0, 1)), thr[6:0]});
		write_reg(CFG_STATIONARY, {7'($urandom_range(0, 127)), stat});
		cfg_valid <= 1'b0;
	endtask

	// wait until every word is taken and every decision checked
	task automatic settle();
		while (n_taken != n_queued || moves_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// main sequence
	initial begin
		int goal;
		int budget;
		peer_pick = {$urandom, $urandom};
		if (peer_pick == '0 || peer_pick == '1)
			peer_pick = 64'h5a5a_0f0f_a5a5_f0f0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// directed: bad header before latch, latch, foreign senders, zero sample, too few
		push_tick();
		push_word(OP_FRAME, 1'b0, peer_pick, 8'h80);
		push_peer(8'h7f);
		push_word(OP_FRAME, 1'b1, 64'h0, 8'h80);
		push_word(OP_FRAME, 1'b1, '1, 8'h00);
		push_peer(8'h00);
		push_peer(8'h80);
		for (int i = 0; i < HIST - 1; i++)
			push_tick();
		settle();

		// random phases over several settings
		for (int p = 0; p < N_SETTINGS; p++) begin
			budget = 170;
			case (p)
				0: set_config(-128, 0, 1'b0);
				1: begin
					write_reg(CFG_UNUSED, 8'($urandom_range(0, 255)));
					set_config(127, 127, 1'b0);
				end
				2: set_config(-30, 1, 1'b0);
				3: begin
					set_config(-50, 5, 1'b1);
					budget = 90;
				end
				4: begin
					set_config(int'($urandom_range(0, 90)) - 100, $urandom_range(0, 12), 1'b0);
					budget = 210;
				end
				default: begin
					set_config(int'($urandom_range(0, 90)) - 100, $urandom_range(0, 12), 1'b0);
					calm   = 1'b1;
					budget = 260;
				end
			endcase
			goal = n_useful + budget;
			if (p == 2) begin
				// receiver holds off while ticks keep coming
				hold_req = 1'b1;
				for (int i = 0; i < 4 * HIST; i++)
					push_tick();
			end
			while (n_useful < goal)
				run_episode();
			settle();
		end

		if (moves_due.size() != 0) begin
			$display("%0t: %0d decision words never arrived", $time, moves_due.size());
			errors++;
		end
		$display("sent %0d words (%0d ticks, counter wrapped %0d times) over %0d settings",
			n_queued, ticks_queued, wraps, N_SETTINGS + 1);
		$display("checked %0d decisions: too few %0d, seeded %0d, target %0d, kept %0d, turned %0d",
			n_checked, outcome_tally[0], outcome_tally[1], outcome_tally[2],
			outcome_tally[3], outcome_tally[4]);
		if (errors == 0) begin
			$display("** rssi_follow_move_decision_top: PASSED **");
		end else begin
			$display("** rssi_follow_move_decision_top: FAILED **");
		end
		$finish;
	end

	// watchdog
	initial begin
		#12_000_000;
		$display("%0t: run did not finish in time", $time);
		$display("** rssi_follow_move_decision_top: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
rtl/rfmd_pkg.sv
rtl/rfmd_ctrl.sv
rtl/rfmd_dp.sv
rtl/rssi_follow_move_decision_top.sv
tb/tb.sv
